### sv/flcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package flcd_pkg;
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;
    localparam logic [1:0] MODE_INVAL = 2'd3;

    localparam logic [1:0] KIND_WB    = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;
    localparam logic [1:0] KIND_INVAL = 2'd3;

    localparam logic [12:0] LS_RESET = 13'd256;
    localparam logic [12:0] LS_MAX   = 13'd4096;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [12:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [11:0] rem;
    } t_div_rsp;
endpackage
`default_nettype wire

### sv/flcd_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module flcd_div import flcd_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    logic [31:0] r_q, n_q;
    logic [12:0] r_r, n_r;
    logic [12:0] r_d;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [13:0] w_sh, w_diff;

    always_comb begin
        w_sh   = {r_r, r_q[31]};
        w_diff = w_sh - {1'b0, r_d};
        n_q = r_q; n_r = r_r; n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        if (i_req.start) begin
            n_q = i_req.dividend; n_r = '0; n_cnt = 6'd0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[13]) begin
                n_r = w_diff[12:0];
                n_q = {r_q[30:0], 1'b1};
            end else begin
                n_r = w_sh[12:0];
                n_q = {r_q[30:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        if (i_req.start) r_d <= i_req.divisor;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_r[11:0];
endmodule
`default_nettype wire

### sv/flash_line_cache_directory_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A read or write runs the divide, then the lookup, the LRU search when the directory is
// full, and a writeback sweep for a dirty victim before it finishes; a flush runs the
// writeback sweep alone, and invalidate answers directly.
// Takes one request at a time; output stalls hold it.
// Reset (synchronous, active low) clears valid/dirty bits, counters and line size 256.
module flash_line_cache_directory_unit import flcd_pkg::*; #(
    parameter int NUM_LINES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [12:0] i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_offset,
    input  wire logic [15:0] i_length,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_kind,
    output logic [3:0]       o_line_index,
    output logic [31:0]      o_line_address,
    output logic             o_hit,
    output logic             o_fill_needed,
    output logic [11:0]      o_offset_in_line,
    output logic [12:0]      o_copy_length,
    output logic [31:0]      o_hit_count,
    output logic [31:0]      o_miss_count,
    output logic             o_last
);
    localparam int IW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int CW = $clog2(NUM_LINES + 1);
    localparam logic [CW-1:0] NL = CW'(NUM_LINES);

    localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_LOOK = 4'd2, S_LRU = 4'd3,
        S_WB = 4'd4, S_WBOUT = 4'd5, S_MUL = 4'd6, S_DONE = 4'd7, S_OUT = 4'd8;

    localparam logic [1:0] RET_FLUSH = 2'd0, RET_MISS = 2'd1;

    logic [31:0]   r_tag   [NUM_LINES];
    logic [31:0]   r_stamp [NUM_LINES];
    logic [NUM_LINES-1:0] r_vld, r_dty;
    logic [CW-1:0] r_used;
    logic [31:0]   r_hits, r_miss;
    logic [12:0]   r_ls;
    logic [3:0]    r_st;
    logic [1:0]    r_mode;
    logic [31:0]   r_off;
    logic [15:0]   r_len;
    logic [31:0]   r_key;
    logic [11:0]   r_oil;
    logic [CW-1:0] r_i;
    logic [IW-1:0] r_idx;
    logic [31:0]   r_best;
    logic          r_hit;
    logic [1:0]    r_ret;   // after writebacks: flush done or finish miss

    t_div_req w_dreq;
    t_div_rsp w_drsp;
    logic [12:0] w_els;
    logic [IW-1:0] w_i;
    logic [44:0] w_prod;
    logic [12:0] w_room;

    assign w_els = (r_ls == 13'd0) ? 13'd1 : ((r_ls > LS_MAX) ? LS_MAX : r_ls);
    assign w_i = r_i[IW-1:0];
    assign w_dreq.start = (r_st == S_IDLE) && i_valid;
    assign w_dreq.dividend = i_offset;
    assign w_dreq.divisor = w_els;
    assign w_prod = {13'd0, o_line_address} * {32'd0, w_els};
    assign w_room = w_els - {1'b0, r_oil};

    flcd_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    assign o_stall = (r_st != S_IDLE);
    assign o_valid = (r_st == S_OUT) || (r_st == S_WBOUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_vld <= '0; r_dty <= '0; r_used <= '0;
            r_hits <= '0; r_miss <= '0; r_ls <= LS_RESET;
        end else begin
            if (i_cfg_we) r_ls <= i_cfg_wdata;
            case (r_st)
            S_IDLE: if (i_valid) begin
                r_mode <= i_mode; r_off <= i_offset; r_len <= i_length;
                r_i <= '0;
                if (i_mode == MODE_FLUSH) begin
                    r_ret <= RET_FLUSH; r_st <= S_WB;
                end else if (i_mode == MODE_INVAL) begin
                    r_vld <= '0; r_dty <= '0; r_used <= '0;
                    r_hits <= '0; r_miss <= '0;
                    o_kind <= KIND_INVAL; o_line_index <= '0; o_line_address <= '0;
                    o_hit <= 1'b0; o_fill_needed <= 1'b0; o_offset_in_line <= '0;
                    o_copy_length <= '0; o_hit_count <= '0; o_miss_count <= '0;
                    o_last <= 1'b1; r_st <= S_OUT;
                end else begin
                    o_kind <= KIND_DONE; o_last <= 1'b1; r_st <= S_DIV;
                end
            end
            S_DIV: if (w_drsp.done) begin
                r_key <= w_drsp.quot; r_oil <= w_drsp.rem; r_st <= S_LOOK;
                o_line_address <= w_drsp.quot;
            end
            S_LOOK: begin
                // walk the used entries one per cycle
                if (r_i < r_used && r_i < NL && r_vld[w_i] && r_tag[w_i] == r_key) begin
                    r_hit <= 1'b1; r_idx <= w_i; r_hits <= r_hits + 32'd1;
                    r_stamp[w_i] <= r_hits + 32'd1 + r_miss;
                    r_st <= S_DONE;
                end else if (r_i < r_used && r_i < NL) begin
                    r_i <= r_i + CW'(1);
                end else begin
                    r_hit <= 1'b0; r_miss <= r_miss + 32'd1;
                    if (r_used < NL) begin
                        r_idx <= r_used[IW-1:0]; r_used <= r_used + CW'(1);
                        r_ret <= RET_MISS; r_st <= S_MUL;
                    end else begin
                        r_best <= r_stamp[0]; r_idx <= '0; r_i <= CW'(1); r_st <= S_LRU;
                    end
                end
            end
            S_LRU: begin
                if (r_i < NL) begin
                    if (r_stamp[w_i] < r_best) begin
                        r_best <= r_stamp[w_i]; r_idx <= w_i;
                    end
                    r_i <= r_i + CW'(1);
                end else if (r_dty[r_idx]) begin
                    r_i <= '0; r_ret <= RET_MISS; r_st <= S_WB;
                end else r_st <= S_MUL;
            end
            S_WB: begin
                // sweep for dirty lines; emit each as writeback
                if (r_i < r_used && r_i < NL) begin
                    if (r_vld[w_i] && r_dty[w_i]) begin
                        r_dty[w_i] <= 1'b0;
                        o_kind <= KIND_WB; o_line_index <= 4'(w_i);
                        o_line_address <= r_tag[w_i]; // scaled in S_MUL
                        o_hit <= 1'b0; o_fill_needed <= 1'b0; o_offset_in_line <= '0;
                        o_copy_length <= w_els; o_hit_count <= r_hits;
                        o_miss_count <= r_miss; o_last <= 1'b0;
                        r_st <= S_MUL;
                    end
                    r_i <= r_i + CW'(1);
                end else if (r_ret == RET_FLUSH) begin
                    o_kind <= KIND_FLUSH; o_line_index <= '0; o_line_address <= '0;
                    o_hit <= 1'b0; o_fill_needed <= 1'b0; o_offset_in_line <= '0;
                    o_copy_length <= '0; o_hit_count <= r_hits; o_miss_count <= r_miss;
                    o_last <= 1'b1; r_st <= S_OUT;
                end else begin
                    o_line_address <= r_key; o_kind <= KIND_DONE; r_st <= S_MUL;
                end
            end
            S_MUL: begin
                // writeback: line address = tag * line size, one multiply, registered; else reload key
                if (o_kind == KIND_WB && !o_last) begin
                    o_line_address <= w_prod[31:0]; r_st <= S_WBOUT;
                end else begin
                    o_line_address <= r_key; o_kind <= KIND_DONE; o_last <= 1'b1;
                    r_st <= S_DONE;
                end
            end
            S_WBOUT: if (!i_stall) r_st <= S_WB;
            S_DONE: begin
                if (!r_hit) begin
                    r_tag[r_idx] <= r_key; r_stamp[r_idx] <= '0;
                    r_vld[r_idx] <= 1'b1; r_dty[r_idx] <= (r_mode == MODE_WRITE);
                end else if (r_mode == MODE_WRITE) r_dty[r_idx] <= 1'b1;
                o_kind <= KIND_DONE; o_line_index <= 4'(r_idx);
                o_line_address <= w_prod[31:0];
                o_hit <= r_hit; o_fill_needed <= !r_hit && (r_mode == MODE_READ);
                o_offset_in_line <= r_oil;
                o_copy_length <= ({13'd0, r_len} < {16'd0, w_room}) ? r_len[12:0] : w_room;
                o_hit_count <= r_hit ? r_hits : r_hits;
                o_miss_count <= r_miss; o_last <= 1'b1;
                r_st <= S_OUT;
            end
            S_OUT: if (!i_stall) r_st <= S_IDLE;
            default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
